### sv/bhs_pkg.sv
package bhs_pkg;

    // Fixed field widths.
    localparam int HEIGHT_W    = 24;
    localparam int COORD_W     = 32;
    localparam int SCALE_W     = 24;
    localparam int COUNT_W     = 9;
    localparam int CELL_IDX_W  = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // The scale product is split into two halves of the coordinate difference.
    localparam int HALF_DIFF_W = COORD_W / 2;
    localparam int PROD_W      = HALF_DIFF_W + SCALE_W;
    localparam int FULL_W      = COORD_W + SCALE_W;

    // Defaults for the top level parameters.
    localparam int DEF_GRID_COLUMNS  = 256;
    localparam int DEF_GRID_ROWS     = 256;
    localparam int DEF_FRACTION_BITS = 8;

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_EAST    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_NORTH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CELLS_PER_UNIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS_IN_USE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE    = 3'd4;

    localparam logic [SCALE_W-1:0] CELLS_PER_UNIT_RESET = 24'd65536;

    // Item kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam int CMD_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_ZERO  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_east;
        logic signed [COORD_W-1:0] origin_north;
        logic [SCALE_W-1:0]        cells_per_unit;
        logic [COUNT_W-1:0]        columns_in_use;
        logic [COUNT_W-1:0]        rows_in_use;
    } cfg_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MUL_LO,
        FS_MUL_HI,
        FS_SUM,
        FS_CLAMP,
        FS_ADDR,
        FS_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_RD1,
        BS_RD2,
        BS_RD3,
        BS_RD4,
        BS_MUL,
        BS_SUM,
        BS_OUT
    } back_state_t;

endpackage

### sv/bhs_queue.sv
module bhs_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty,
    output logic             full
);

    localparam int DEPTH = bhs_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW:0]      rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      fill;

    assign fill  = wr_ptr_reg - rd_ptr_reg;
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (fill == (PW + 1)'(DEPTH));
    assign head  = entry_reg[rd_ptr_reg[PW-1:0]];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push && !full)
        begin
            wr_ptr_next = wr_ptr_reg + (PW + 1)'(1);
        end
        if (pop && !empty)
        begin
            rd_ptr_next = rd_ptr_reg + (PW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg[PW-1:0]] <= push_data;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= (PW + 1)'(DEPTH))
        else $error("queue fill count exceeds depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into a full queue");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !pop) |=> !empty)
        else $error("queue empty after a transfer in");

endmodule

### sv/bhs_front.sv
module bhs_front #(
    parameter int GRID_COLUMNS  = bhs_pkg::DEF_GRID_COLUMNS,
    parameter int GRID_ROWS     = bhs_pkg::DEF_GRID_ROWS,
    parameter int FRACTION_BITS = bhs_pkg::DEF_FRACTION_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bhs_pkg::cfg_t                        cfg,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 kind,
    input  logic [bhs_pkg::CELL_IDX_W-1:0]       load_column,
    input  logic [bhs_pkg::CELL_IDX_W-1:0]       load_row,
    input  logic signed [bhs_pkg::HEIGHT_W-1:0]  load_height,
    input  logic signed [bhs_pkg::COORD_W-1:0]   query_east,
    input  logic signed [bhs_pkg::COORD_W-1:0]   query_north,
    input  logic                                 q_full,
    output logic                                 q_push,
    output logic [bhs_pkg::CMD_W + 4 * $clog2(GRID_COLUMNS * GRID_ROWS)
                  + 2 * FRACTION_BITS + bhs_pkg::HEIGHT_W - 1:0] q_entry
);

    localparam int F    = FRACTION_BITS;
    localparam int AW   = $clog2(GRID_COLUMNS * GRID_ROWS);
    localparam int CB   = $clog2(GRID_COLUMNS);
    localparam int RB   = $clog2(GRID_ROWS);
    localparam int CW   = $clog2(GRID_COLUMNS + 1);
    localparam int RW   = $clog2(GRID_ROWS + 1);
    localparam int CMPC = (CW > bhs_pkg::COUNT_W) ? CW : bhs_pkg::COUNT_W;
    localparam int CMPR = (RW > bhs_pkg::COUNT_W) ? RW : bhs_pkg::COUNT_W;
    localparam int DW   = bhs_pkg::COORD_W;
    localparam int HDW  = bhs_pkg::HALF_DIFF_W;
    localparam int PW   = bhs_pkg::PROD_W;
    localparam int FW   = bhs_pkg::FULL_W;
    localparam int QW   = FW - bhs_pkg::SCALE_W + F;
    localparam int PXW  = CB + F;
    localparam int PYW  = RB + F;
    localparam int HW   = bhs_pkg::HEIGHT_W;
    localparam logic [QW-1:0] HALF_Q = QW'(1) << (F - 1);

    bhs_pkg::front_state_t state_reg, state_next;

    logic                  kind_reg, kind_next;
    logic                  pos_e_reg, pos_e_next;
    logic                  pos_n_reg, pos_n_next;
    logic [DW-1:0]         de_reg, de_next;
    logic [DW-1:0]         dn_reg, dn_next;
    logic [PW-1:0]         plo_e_reg, plo_e_next;
    logic [PW-1:0]         plo_n_reg, plo_n_next;
    logic [PW-1:0]         phi_e_reg, phi_e_next;
    logic [PW-1:0]         phi_n_reg, phi_n_next;
    logic [QW-1:0]         qe_reg, qe_next;
    logic [QW-1:0]         qn_reg, qn_next;
    logic [PXW-1:0]        x_reg, x_next;
    logic [PYW-1:0]        y_reg, y_next;
    logic [AW-1:0]         a00_reg, a00_next;
    logic [AW-1:0]         a01_reg, a01_next;
    logic [AW-1:0]         a10_reg, a10_next;
    logic [AW-1:0]         a11_reg, a11_next;
    logic [F-1:0]          fx_reg, fx_next;
    logic [F-1:0]          fy_reg, fy_next;
    logic [HW-1:0]         height_reg, height_next;

    logic [DW:0]           diff_e, diff_n;
    logic                  pos_e, pos_n;
    logic                  load_ok;
    logic [AW-1:0]         load_addr;
    logic [CW-1:0]         cols;
    logic [RW-1:0]         rows;
    logic                  grid_empty;
    logic [QW-1:0]         lim_x, lim_y;
    logic [QW-1:0]         x_sub, y_sub, x_pos, y_pos;
    logic [FW-1:0]         full_e, full_n;
    logic [CB-1:0]         col, ncol;
    logic [RB-1:0]         row, nrow;
    logic [CW-1:0]         col_inc;
    logic [RW-1:0]         row_inc;
    bhs_pkg::cmd_t         cmd;

    // Exact 33-bit differences; northing grows toward row 0, so it is reversed.
    assign diff_e = {query_east[DW-1], query_east} - {cfg.origin_east[DW-1], cfg.origin_east};
    assign diff_n = {cfg.origin_north[DW-1], cfg.origin_north} - {query_north[DW-1], query_north};
    assign pos_e  = !diff_e[DW] && (diff_e != '0);
    assign pos_n  = !diff_n[DW] && (diff_n != '0);

    assign load_ok   = (32'(load_column) < GRID_COLUMNS) && (32'(load_row) < GRID_ROWS);
    assign load_addr = AW'(32'(load_row) * 32'(GRID_COLUMNS) + 32'(load_column));

    assign cols = (CMPC'(cfg.columns_in_use) > CMPC'(GRID_COLUMNS)) ?
                  CW'(GRID_COLUMNS) : CW'(cfg.columns_in_use);
    assign rows = (CMPR'(cfg.rows_in_use) > CMPR'(GRID_ROWS)) ?
                  RW'(GRID_ROWS) : RW'(cfg.rows_in_use);
    assign grid_empty = (cols == '0) || (rows == '0);

    assign lim_x = QW'(cols - CW'(1)) << F;
    assign lim_y = QW'(rows - RW'(1)) << F;

    assign full_e = FW'(plo_e_reg) + (FW'(phi_e_reg) << HDW);
    assign full_n = FW'(plo_n_reg) + (FW'(phi_n_reg) << HDW);

    // Position in cells from the centre of the first cell, clamped to the grid.
    assign x_sub = qe_reg - HALF_Q;
    assign y_sub = qn_reg - HALF_Q;
    assign x_pos = (!pos_e_reg || qe_reg <= HALF_Q) ? '0 : ((x_sub > lim_x) ? lim_x : x_sub);
    assign y_pos = (!pos_n_reg || qn_reg <= HALF_Q) ? '0 : ((y_sub > lim_y) ? lim_y : y_sub);

    assign col     = x_reg[PXW-1:F];
    assign row     = y_reg[PYW-1:F];
    assign col_inc = CW'(col) + CW'(1);
    assign row_inc = RW'(row) + RW'(1);
    assign ncol    = (col_inc < cols) ? CB'(col_inc) : CB'(cols - CW'(1));
    assign nrow    = (row_inc < rows) ? RB'(row_inc) : RB'(rows - RW'(1));

    always_comb
    begin
        if (kind_reg == bhs_pkg::KIND_LOAD)
        begin
            cmd = bhs_pkg::CMD_LOAD;
        end
        else if (grid_empty)
        begin
            cmd = bhs_pkg::CMD_ZERO;
        end
        else
        begin
            cmd = bhs_pkg::CMD_QUERY;
        end
    end

    assign q_entry = {cmd, a00_reg, a01_reg, a10_reg, a11_reg, fx_reg, fy_reg, height_reg};

    always_comb
    begin
        state_next  = state_reg;
        in_stall    = (state_reg != bhs_pkg::FS_IDLE);
        q_push      = 1'b0;
        kind_next   = kind_reg;
        pos_e_next  = pos_e_reg;
        pos_n_next  = pos_n_reg;
        de_next     = de_reg;
        dn_next     = dn_reg;
        plo_e_next  = plo_e_reg;
        plo_n_next  = plo_n_reg;
        phi_e_next  = phi_e_reg;
        phi_n_next  = phi_n_reg;
        qe_next     = qe_reg;
        qn_next     = qn_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        a00_next    = a00_reg;
        a01_next    = a01_reg;
        a10_next    = a10_reg;
        a11_next    = a11_reg;
        fx_next     = fx_reg;
        fy_next     = fy_reg;
        height_next = height_reg;
        case (state_reg)
            bhs_pkg::FS_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next   = kind;
                    pos_e_next  = pos_e;
                    pos_n_next  = pos_n;
                    de_next     = diff_e[DW-1:0];
                    dn_next     = diff_n[DW-1:0];
                    height_next = load_height;
                    a00_next    = load_addr;
                    if (kind == bhs_pkg::KIND_QUERY)
                    begin
                        state_next = bhs_pkg::FS_MUL_LO;
                    end
                    else if (load_ok)
                    begin
                        state_next = bhs_pkg::FS_PUSH;
                    end
                end
            end
            bhs_pkg::FS_MUL_LO:
            begin
                plo_e_next = PW'(de_reg[HDW-1:0]) * PW'(cfg.cells_per_unit);
                plo_n_next = PW'(dn_reg[HDW-1:0]) * PW'(cfg.cells_per_unit);
                state_next = bhs_pkg::FS_MUL_HI;
            end
            bhs_pkg::FS_MUL_HI:
            begin
                phi_e_next = PW'(de_reg[DW-1:HDW]) * PW'(cfg.cells_per_unit);
                phi_n_next = PW'(dn_reg[DW-1:HDW]) * PW'(cfg.cells_per_unit);
                state_next = bhs_pkg::FS_SUM;
            end
            bhs_pkg::FS_SUM:
            begin
                qe_next    = full_e[FW-1:bhs_pkg::SCALE_W-F];
                qn_next    = full_n[FW-1:bhs_pkg::SCALE_W-F];
                state_next = bhs_pkg::FS_CLAMP;
            end
            bhs_pkg::FS_CLAMP:
            begin
                x_next     = x_pos[PXW-1:0];
                y_next     = y_pos[PYW-1:0];
                state_next = bhs_pkg::FS_ADDR;
            end
            bhs_pkg::FS_ADDR:
            begin
                fx_next    = x_reg[F-1:0];
                fy_next    = y_reg[F-1:0];
                a00_next   = AW'(32'(row) * 32'(GRID_COLUMNS) + 32'(col));
                a01_next   = AW'(32'(row) * 32'(GRID_COLUMNS) + 32'(ncol));
                a10_next   = AW'(32'(nrow) * 32'(GRID_COLUMNS) + 32'(col));
                a11_next   = AW'(32'(nrow) * 32'(GRID_COLUMNS) + 32'(ncol));
                state_next = bhs_pkg::FS_PUSH;
            end
            bhs_pkg::FS_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = bhs_pkg::FS_IDLE;
                end
            end
            default:
            begin
                state_next = bhs_pkg::FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bhs_pkg::FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        pos_e_reg  <= pos_e_next;
        pos_n_reg  <= pos_n_next;
        de_reg     <= de_next;
        dn_reg     <= dn_next;
        plo_e_reg  <= plo_e_next;
        plo_n_reg  <= plo_n_next;
        phi_e_reg  <= phi_e_next;
        phi_n_reg  <= phi_n_next;
        qe_reg     <= qe_next;
        qn_reg     <= qn_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        a00_reg    <= a00_next;
        a01_reg    <= a01_next;
        a10_reg    <= a10_next;
        a11_reg    <= a11_next;
        fx_reg     <= fx_next;
        fy_reg     <= fy_next;
        height_reg <= height_next;
    end

endmodule

### sv/bhs_back.sv
module bhs_back #(
    parameter int GRID_COLUMNS  = bhs_pkg::DEF_GRID_COLUMNS,
    parameter int GRID_ROWS     = bhs_pkg::DEF_GRID_ROWS,
    parameter int FRACTION_BITS = bhs_pkg::DEF_FRACTION_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_empty,
    input  logic [bhs_pkg::CMD_W + 4 * $clog2(GRID_COLUMNS * GRID_ROWS)
                  + 2 * FRACTION_BITS + bhs_pkg::HEIGHT_W - 1:0] q_entry,
    output logic                                 q_pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [bhs_pkg::HEIGHT_W-1:0]  height_out
);

    localparam int F     = FRACTION_BITS;
    localparam int DEPTH = GRID_COLUMNS * GRID_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int HW    = bhs_pkg::HEIGHT_W;
    localparam int TW    = HW + F + 1;
    localparam int SW    = HW + 2 * F + 2;
    localparam logic [F:0]    ONE_W = (F + 1)'(1) << F;
    localparam logic [SW-1:0] ROUND = SW'(1) << (2 * F - 1);

    bhs_pkg::back_state_t state_reg, state_next;

    logic [bhs_pkg::CMD_W-1:0] h_cmd_bits;
    bhs_pkg::cmd_t             h_cmd;
    logic [AW-1:0]             h_a00, h_a01, h_a10, h_a11;
    logic [F-1:0]              h_fx, h_fy;
    logic [HW-1:0]             h_height;

    logic [AW-1:0]             a01_reg, a01_next;
    logic [AW-1:0]             a10_reg, a10_next;
    logic [AW-1:0]             a11_reg, a11_next;
    logic [F-1:0]              fx_reg, fx_next;
    logic [F-1:0]              fy_reg, fy_next;
    logic signed [TW-1:0]      top_reg, top_next;
    logic signed [TW-1:0]      bot_reg, bot_next;
    logic signed [SW-1:0]      vtop_reg, vtop_next;
    logic signed [SW-1:0]      sum_reg, sum_next;
    logic                      out_valid_reg, out_valid_next;
    logic [HW-1:0]             height_reg, height_next;

    logic [HW-1:0]             grid_mem [DEPTH];
    logic [HW-1:0]             rd_data_reg;
    logic [AW-1:0]             rd_addr;
    logic                      mem_we;

    logic signed [TW-1:0]      h_ext, wx0_ext, fx_ext;
    logic signed [SW-1:0]      top_w, bot_w, wy0_ext, fy_ext;
    logic                      out_free;

    assign {h_cmd_bits, h_a00, h_a01, h_a10, h_a11, h_fx, h_fy, h_height} = q_entry;
    assign h_cmd = bhs_pkg::cmd_t'(h_cmd_bits);

    assign h_ext   = TW'(signed'(rd_data_reg));
    assign wx0_ext = TW'(ONE_W - (F + 1)'(fx_reg));
    assign fx_ext  = TW'(fx_reg);
    assign top_w   = SW'(top_reg);
    assign bot_w   = SW'(bot_reg);
    assign wy0_ext = SW'(ONE_W - (F + 1)'(fy_reg));
    assign fy_ext  = SW'(fy_reg);

    assign out_free   = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign height_out = height_reg;

    always_comb
    begin
        state_next     = state_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        rd_addr        = a11_reg;
        a01_next       = a01_reg;
        a10_next       = a10_reg;
        a11_next       = a11_reg;
        fx_next        = fx_reg;
        fy_next        = fy_reg;
        top_next       = top_reg;
        bot_next       = bot_reg;
        vtop_next      = vtop_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && out_stall;
        height_next    = height_reg;
        case (state_reg)
            bhs_pkg::BS_IDLE:
            begin
                rd_addr = h_a00;
                if (!q_empty)
                begin
                    case (h_cmd)
                        bhs_pkg::CMD_LOAD:
                        begin
                            mem_we = 1'b1;
                            q_pop  = 1'b1;
                        end
                        bhs_pkg::CMD_QUERY:
                        begin
                            q_pop      = 1'b1;
                            a01_next   = h_a01;
                            a10_next   = h_a10;
                            a11_next   = h_a11;
                            fx_next    = h_fx;
                            fy_next    = h_fy;
                            state_next = bhs_pkg::BS_RD1;
                        end
                        default:
                        begin
                            // Empty grid: the answer is zero and needs no reads.
                            if (out_free)
                            begin
                                q_pop          = 1'b1;
                                out_valid_next = 1'b1;
                                height_next    = '0;
                            end
                        end
                    endcase
                end
            end
            bhs_pkg::BS_RD1:
            begin
                rd_addr    = a01_reg;
                top_next   = h_ext * wx0_ext;
                state_next = bhs_pkg::BS_RD2;
            end
            bhs_pkg::BS_RD2:
            begin
                rd_addr    = a10_reg;
                top_next   = top_reg + h_ext * fx_ext;
                state_next = bhs_pkg::BS_RD3;
            end
            bhs_pkg::BS_RD3:
            begin
                rd_addr    = a11_reg;
                bot_next   = h_ext * wx0_ext;
                state_next = bhs_pkg::BS_RD4;
            end
            bhs_pkg::BS_RD4:
            begin
                bot_next   = bot_reg + h_ext * fx_ext;
                state_next = bhs_pkg::BS_MUL;
            end
            bhs_pkg::BS_MUL:
            begin
                vtop_next  = top_w * wy0_ext;
                state_next = bhs_pkg::BS_SUM;
            end
            bhs_pkg::BS_SUM:
            begin
                sum_next   = vtop_reg + bot_w * fy_ext + ROUND;
                state_next = bhs_pkg::BS_OUT;
            end
            bhs_pkg::BS_OUT:
            begin
                if (out_free)
                begin
                    // Taking the upper bits floors, so ties round upward.
                    out_valid_next = 1'b1;
                    height_next    = sum_reg[2 * F + HW - 1:2 * F];
                    state_next     = bhs_pkg::BS_IDLE;
                end
            end
            default:
            begin
                state_next = bhs_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bhs_pkg::BS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a01_reg    <= a01_next;
        a10_reg    <= a10_next;
        a11_reg    <= a11_next;
        fx_reg     <= fx_next;
        fy_reg     <= fy_next;
        top_reg    <= top_next;
        bot_reg    <= bot_next;
        vtop_reg   <= vtop_next;
        sum_reg    <= sum_next;
        height_reg <= height_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[h_a00] <= h_height;
        end
        rd_data_reg <= grid_mem[rd_addr];
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command taken from an empty queue");

    a_query_starts_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bhs_pkg::BS_IDLE && q_pop && h_cmd == bhs_pkg::CMD_QUERY)
        |=> (state_reg == bhs_pkg::BS_RD1))
        else $error("query did not start its cell reads");

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bhs_pkg::BS_OUT && out_valid_reg && out_stall)
        |=> (state_reg == bhs_pkg::BS_OUT))
        else $error("blended result dropped while output was stalled");

    a_write_with_pop: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (q_pop && state_reg == bhs_pkg::BS_IDLE))
        else $error("grid written outside a load command");

endmodule

### sv/bilinear_height_sampler_core.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  kind, load_column, load_row, load_height,
//                                           query_east, query_north
// out       output     out_valid/out_stall  height_out
// cfg       input      cfg_write            cfg_index, cfg_data
//
// An in-range load is pushed by the front and written by the back; a query passes the front
// (two-half scale multiply, clamp, address) and then the back (cell reads, blend, output).
// The sustained query rate is set by the four reads through the single read port of the
// height memory and the two blend steps; the two-entry queue overlaps front and back.
// Reset clears control state and config only; the height memory is not cleared.
// A stalled result is held in the output register while the next item is accepted.
module bilinear_height_sampler_core #(
    parameter int GRID_COLUMNS  = bhs_pkg::DEF_GRID_COLUMNS,
    parameter int GRID_ROWS     = bhs_pkg::DEF_GRID_ROWS,
    parameter int FRACTION_BITS = bhs_pkg::DEF_FRACTION_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [bhs_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [bhs_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 kind,
    input  logic [bhs_pkg::CELL_IDX_W-1:0]       load_column,
    input  logic [bhs_pkg::CELL_IDX_W-1:0]       load_row,
    input  logic signed [bhs_pkg::HEIGHT_W-1:0]  load_height,
    input  logic signed [bhs_pkg::COORD_W-1:0]   query_east,
    input  logic signed [bhs_pkg::COORD_W-1:0]   query_north,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [bhs_pkg::HEIGHT_W-1:0]  height_out
);

    localparam int AW      = $clog2(GRID_COLUMNS * GRID_ROWS);
    localparam int ENTRY_W = bhs_pkg::CMD_W + 4 * AW + 2 * FRACTION_BITS + bhs_pkg::HEIGHT_W;

    bhs_pkg::cfg_t        cfg_reg, cfg_next;
    logic                 q_push, q_pop, q_empty, q_full;
    logic [ENTRY_W-1:0]   q_push_data, q_head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                bhs_pkg::REG_ORIGIN_EAST:
                begin
                    cfg_next.origin_east = cfg_data;
                end
                bhs_pkg::REG_ORIGIN_NORTH:
                begin
                    cfg_next.origin_north = cfg_data;
                end
                bhs_pkg::REG_CELLS_PER_UNIT:
                begin
                    cfg_next.cells_per_unit = cfg_data[bhs_pkg::SCALE_W-1:0];
                end
                bhs_pkg::REG_COLUMNS_IN_USE:
                begin
                    cfg_next.columns_in_use = cfg_data[bhs_pkg::COUNT_W-1:0];
                end
                bhs_pkg::REG_ROWS_IN_USE:
                begin
                    cfg_next.rows_in_use = cfg_data[bhs_pkg::COUNT_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_east    <= '0;
            cfg_reg.origin_north   <= '0;
            cfg_reg.cells_per_unit <= bhs_pkg::CELLS_PER_UNIT_RESET;
            cfg_reg.columns_in_use <= '0;
            cfg_reg.rows_in_use    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bhs_front #(
        .GRID_COLUMNS  (GRID_COLUMNS),
        .GRID_ROWS     (GRID_ROWS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .load_column (load_column),
        .load_row    (load_row),
        .load_height (load_height),
        .query_east  (query_east),
        .query_north (query_north),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_push_data)
    );

    bhs_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    bhs_back #(
        .GRID_COLUMNS  (GRID_COLUMNS),
        .GRID_ROWS     (GRID_ROWS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_entry    (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .height_out (height_out)
    );

endmodule
